// ===== design/tla_pkg.sv =====
// Shared types, character codes and helpers for the terminal line assembler.
`default_nettype none
package tla_pkg;

    // result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_KEY  = 2'd2;

    // characters
    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_BRACKET = 8'h5b;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_UP      = 8'h41;
    localparam logic [7:0] CH_DOWN    = 8'h42;
    localparam logic [7:0] CH_RIGHT   = 8'h43;
    localparam logic [7:0] CH_LEFT    = 8'h44;

    // arrow key codes
    localparam logic [7:0] KEY_UP    = 8'd0;
    localparam logic [7:0] KEY_DOWN  = 8'd1;
    localparam logic [7:0] KEY_LEFT  = 8'd2;
    localparam logic [7:0] KEY_RIGHT = 8'd3;

    // input commands
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // prefix sequence "!!!" CR LF; the empty line starts at PREFIX_CR
    localparam logic [2:0] PREFIX_FIRST = 3'd0;
    localparam logic [2:0] PREFIX_CR    = 3'd3;
    localparam logic [2:0] PREFIX_LF    = 3'd4;

    typedef enum logic [1:0] {
        OP_ECHO,
        OP_KEY,
        OP_CR_EMPTY,
        OP_CR_LINE
    } op_t;

    // work handed from front to back; for OP_CR_LINE data holds the fill count
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0, 3'd1, 3'd2: ch = CH_BANG;
            PREFIX_CR:        ch = CH_CR;
            default:          ch = CH_LF;
        endcase
        return ch;
    endfunction

    // {hit, code} for the third byte of an escape sequence
    function automatic logic [8:0] arrow_code(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_UP:    r = {1'b1, KEY_UP};
            CH_DOWN:  r = {1'b1, KEY_DOWN};
            CH_LEFT:  r = {1'b1, KEY_LEFT};
            CH_RIGHT: r = {1'b1, KEY_RIGHT};
            default:  r = {1'b0, 8'd0};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/tla_front.sv =====
// Front end: accepts input transactions, tracks the fill count and classifies bytes.
`default_nettype none
module tla_front #(
    parameter int BUFFER_DEPTH = 32,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  wire              s_command,
    input  wire  [7:0]       s_data_in,
    // queue push side
    output logic             q_push,
    output tla_pkg::cmd_t    q_cmd,
    input  wire              q_full,
    // line store write port
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic [7:0]       wr_data,
    // back end finished the line dump
    input  wire              flush_done
);

    logic [AW-1:0] fill_reg, fill_next;
    logic          first_esc_reg, first_esc_next;
    logic          bracket_reg, bracket_next;
    logic          pending_reg, pending_next;
    logic          accept;
    logic          esc_line;
    logic [8:0]    arrow;

    assign s_ready = !pending_reg && !q_full;
    assign accept  = s_valid && s_ready;
    assign arrow   = tla_pkg::arrow_code(s_data_in);
    assign esc_line = (fill_reg == '0) ? (s_data_in == tla_pkg::CH_ESC) : first_esc_reg;

    assign wr_addr = fill_reg;
    assign wr_data = s_data_in;

    always_comb begin
        fill_next      = fill_reg;
        first_esc_next = first_esc_reg;
        bracket_next   = bracket_reg;
        pending_next   = pending_reg;
        q_push         = 1'b0;
        q_cmd.op       = tla_pkg::OP_ECHO;
        q_cmd.data     = s_data_in;
        wr_en          = 1'b0;
        if (flush_done) begin
            pending_next = 1'b0;
        end
        if (accept) begin
            if (s_command == tla_pkg::CMD_TIMEOUT) begin
                fill_next = '0;
            end else if (s_data_in == tla_pkg::CH_CR) begin
                q_push = 1'b1;
                if (fill_reg != '0) begin
                    q_cmd.op     = tla_pkg::OP_CR_LINE;
                    q_cmd.data   = 8'(fill_reg);
                    fill_next    = '0;
                    pending_next = 1'b1;
                end else begin
                    q_cmd.op = tla_pkg::OP_CR_EMPTY;
                end
            end else if (fill_reg < AW'(BUFFER_DEPTH - 1)) begin
                wr_en     = 1'b1;
                fill_next = fill_reg + 1'b1;
                if (fill_reg == AW'(0)) begin
                    first_esc_next = (s_data_in == tla_pkg::CH_ESC);
                end
                if (fill_reg == AW'(1)) begin
                    bracket_next = (s_data_in == tla_pkg::CH_BRACKET);
                end
                if (!esc_line) begin
                    q_push = 1'b1;
                end else if (fill_reg == AW'(2) && bracket_reg && arrow[8]) begin
                    q_push     = 1'b1;
                    q_cmd.op   = tla_pkg::OP_KEY;
                    q_cmd.data = arrow[7:0];
                    fill_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            first_esc_reg <= 1'b0;
            bracket_reg   <= 1'b0;
            pending_reg   <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            first_esc_reg <= first_esc_next;
            bracket_reg   <= bracket_next;
            pending_reg   <= pending_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/tla_queue.sv =====
// Two-entry command queue between front and back end.
`default_nettype none
module tla_queue (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  tla_pkg::cmd_t    push_cmd,
    output logic             full,
    input  wire              pop,
    output logic             head_valid,
    output tla_pkg::cmd_t    head_cmd
);

    tla_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/tla_back.sv =====
// Back end: line store memory and result sequencer with output register.
`default_nettype none
module tla_back #(
    parameter int BUFFER_DEPTH = 32,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  wire              aclk,
    input  wire              aresetn,
    // queue pop side
    input  wire              q_valid,
    input  tla_pkg::cmd_t    q_cmd,
    output logic             q_pop,
    // line store write port
    input  wire              wr_en,
    input  wire  [AW-1:0]    wr_addr,
    input  wire  [7:0]       wr_data,
    output logic             flush_done,
    // result channel
    output logic             m_valid,
    input  wire              m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_data_out,
    output logic             m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_FETCH,
        ST_EMIT
    } state_t;

    logic [7:0]    line_mem [BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    state_t        state_reg;
    logic [2:0]    seq_reg;
    logic          is_line_reg;
    logic [AW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    logic          m_valid_reg;
    logic [1:0]    m_kind_reg;
    logic [7:0]    m_data_reg;
    logic          m_last_reg;
    logic          out_free;
    logic          out_load;
    logic          last_byte;

    assign out_free   = !m_valid_reg || m_ready;
    assign last_byte  = (idx_reg == count_reg - 1'b1);
    assign q_pop      = (state_reg == ST_IDLE) && q_valid && out_free;
    assign flush_done = (state_reg == ST_EMIT) && out_free && last_byte;
    assign rd_en      = (state_reg == ST_FETCH)
                     || ((state_reg == ST_EMIT) && out_free && !last_byte);
    assign rd_addr    = (state_reg == ST_FETCH) ? '0 : idx_reg + 1'b1;
    // a new result enters the output register this cycle
    assign out_load   = (q_pop && (q_cmd.op inside {tla_pkg::OP_ECHO, tla_pkg::OP_KEY}))
                     || (((state_reg == ST_PREFIX) || (state_reg == ST_EMIT)) && out_free);

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_data_out = m_data_reg;
    assign m_last     = m_last_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            seq_reg     <= tla_pkg::PREFIX_FIRST;
            is_line_reg <= 1'b0;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_kind_reg  <= tla_pkg::KIND_ECHO;
            m_data_reg  <= 8'd0;
            m_last_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        case (q_cmd.op)
                            tla_pkg::OP_ECHO, tla_pkg::OP_KEY: begin
                                m_kind_reg  <= (q_cmd.op == tla_pkg::OP_KEY) ?
                                               tla_pkg::KIND_KEY : tla_pkg::KIND_ECHO;
                                m_data_reg  <= q_cmd.data;
                                m_last_reg  <= 1'b1;
                            end
                            tla_pkg::OP_CR_EMPTY: begin
                                seq_reg     <= tla_pkg::PREFIX_CR;
                                is_line_reg <= 1'b0;
                                state_reg   <= ST_PREFIX;
                            end
                            default: begin
                                seq_reg     <= tla_pkg::PREFIX_FIRST;
                                is_line_reg <= 1'b1;
                                count_reg   <= q_cmd.data[AW-1:0];
                                state_reg   <= ST_PREFIX;
                            end
                        endcase
                    end
                end
                ST_PREFIX: begin
                    if (out_free) begin
                        m_kind_reg  <= tla_pkg::KIND_ECHO;
                        m_data_reg  <= tla_pkg::prefix_char(seq_reg);
                        m_last_reg  <= (seq_reg == tla_pkg::PREFIX_LF) && !is_line_reg;
                        if (seq_reg == tla_pkg::PREFIX_LF) begin
                            state_reg <= is_line_reg ? ST_FETCH : ST_IDLE;
                        end else begin
                            seq_reg <= seq_reg + 3'd1;
                        end
                    end
                end
                ST_FETCH: begin
                    idx_reg   <= '0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    // rd_data_reg holds line_mem[idx_reg]; next byte is read in parallel
                    if (out_free) begin
                        m_kind_reg  <= tla_pkg::KIND_LINE;
                        m_data_reg  <= rd_data_reg;
                        m_last_reg  <= last_byte;
                        if (last_byte) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/terminal_line_assembler.sv =====
// Top level of the terminal line assembler: front end, command queue, back end.
//
// Input channel (s_valid/s_ready): one transaction per received terminal byte
// (s_command = 0, byte on s_data_in) or idle timeout (s_command = 1).
// Result channel (m_valid/m_ready): echo bytes, completed line bytes and arrow
// key codes on m_kind/m_data_out; m_last marks the final result of an input.
// A byte's echo or key code is registered in the queue and then loaded into the
// output register. Bytes that only update the line are held off only while the
// 2-entry queue is full or a line is being read out. A carriage return with n
// stored bytes yields 5 + n results, one per cycle while the receiver is ready,
// with a fetch bubble in ST_FETCH between the prefix and the line bytes; the
// single read port of the line store sets that pace. Input is held off from a
// nonempty carriage return until its last line byte is in the output register.
// Reset (aresetn low, synchronous) empties the line and the queue and drops a
// result waiting in the output register; the line store itself is not cleared.
// When the receiver stalls, the output register holds its result, the queue
// fills, and s_ready falls once the queue is full.
`default_nettype none
module terminal_line_assembler #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire        s_command,
    input  wire  [7:0] s_data_in,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_out,
    output logic       m_last
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          q_push, q_full, q_pop, q_valid;
    tla_pkg::cmd_t push_cmd, head_cmd;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          flush_done;

    tla_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_data_in  (s_data_in),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .q_full     (q_full),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .flush_done (flush_done)
    );

    tla_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    tla_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .flush_done (flush_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_data_out (m_data_out),
        .m_last     (m_last)
    );

endmodule
`default_nettype wire

// ===== design/tla_checker.sv =====
// Port-level checker for the terminal line assembler and its bind.
`default_nettype none
module tla_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire [1:0] m_kind,
    input wire [7:0] m_data_out,
    input wire       m_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_last))
        else $error("result changed while stalled");

    // key codes stand alone and are in range
    a_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == tla_pkg::KIND_KEY |-> m_last && m_data_out <= tla_pkg::KEY_RIGHT)
        else $error("bad arrow key result");

    // line bytes stream back to back until the last one
    a_line_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == tla_pkg::KIND_LINE && !m_last
        |=> m_valid && m_kind == tla_pkg::KIND_LINE)
        else $error("gap inside line output");

    // reset leaves the result channel empty
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an offered input transaction stays offered until accepted
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input withdrawn before acceptance");

endmodule

bind terminal_line_assembler tla_checker u_tla_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_kind     (m_kind),
    .m_data_out (m_data_out),
    .m_last     (m_last)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the terminal line assembler: line/echo predictor and stimulus.
`default_nettype none

class line_echo_scoreboard;
    localparam int DEPTH = 32;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    logic [7:0] line_bytes [DEPTH];
    logic [5:0] fill;
    out_byte_t  expected_out [$];
    int errors, items, results, lines_done, empty_lines, keys, dropped, timeouts;

    function new();
        fill = '0;
        errors = 0; items = 0; results = 0; lines_done = 0; empty_lines = 0;
        keys = 0; dropped = 0; timeouts = 0;
    endfunction

    function void push(input logic [1:0] kind, input logic [7:0] data);
        out_byte_t r;
        r.kind = kind;
        r.data = data;
        r.last = 1'b0;
        expected_out.push_back(r);
    endfunction

    // Predict the results caused by one accepted input transaction.
    function void accept_keystroke(input logic cmd, input logic [7:0] b);
        int         size_at_entry;
        logic [8:0] key;
        out_byte_t  tail;
        size_at_entry = expected_out.size();
        if (cmd == tla_pkg::CMD_TIMEOUT) begin
            fill = '0;
            timeouts++;
            items++;
            return;
        end
        if (b == tla_pkg::CH_CR) begin
            if (fill != 0) begin
                repeat (3) push(tla_pkg::KIND_ECHO, tla_pkg::CH_BANG);
                push(tla_pkg::KIND_ECHO, tla_pkg::CH_CR);
                push(tla_pkg::KIND_ECHO, tla_pkg::CH_LF);
                for (int i = 0; i < fill; i++)
                    push(tla_pkg::KIND_LINE, line_bytes[i]);
                fill = '0;
                lines_done++;
            end else begin
                push(tla_pkg::KIND_ECHO, tla_pkg::CH_CR);
                push(tla_pkg::KIND_ECHO, tla_pkg::CH_LF);
                empty_lines++;
            end
        end else if (fill < DEPTH - 1) begin
            line_bytes[fill[4:0]] = b;
            fill++;
            if (line_bytes[0] == tla_pkg::CH_ESC) begin
                // escape lines are silent until they form a complete arrow sequence
                if (fill == 3 && line_bytes[1] == tla_pkg::CH_BRACKET) begin
                    case (line_bytes[2])
                        tla_pkg::CH_UP:    key = {1'b1, tla_pkg::KEY_UP};
                        tla_pkg::CH_DOWN:  key = {1'b1, tla_pkg::KEY_DOWN};
                        tla_pkg::CH_LEFT:  key = {1'b1, tla_pkg::KEY_LEFT};
                        tla_pkg::CH_RIGHT: key = {1'b1, tla_pkg::KEY_RIGHT};
                        default:           key = '0;
                    endcase
                    if (key[8]) begin
                        push(tla_pkg::KIND_KEY, key[7:0]);
                        fill = '0;
                        keys++;
                    end
                end
            end else begin
                push(tla_pkg::KIND_ECHO, b);
            end
        end else begin
            // full line: byte is discarded without any output
            dropped++;
            items++;
            return;
        end
        items++;
        if (expected_out.size() > size_at_entry) begin
            tail = expected_out.pop_back();
            tail.last = 1'b1;
            expected_out.push_back(tail);
        end
    endfunction

    function void check_output(input logic [1:0] kind, input logic [7:0] data,
                               input logic last);
        out_byte_t e;
        results++;
        if (expected_out.size() == 0) begin
            $display("%0t: unexpected result kind %0d data 0x%02h last %0d",
                     $time, kind, data, last);
            errors++;
            return;
        end
        e = expected_out.pop_front();
        if (kind !== e.kind) begin
            $display("%0t: m_kind expected %0d actual %0d", $time, e.kind, kind);
            errors++;
        end
        if (data !== e.data) begin
            $display("%0t: m_data_out expected 0x%02h actual 0x%02h", $time, e.data, data);
            errors++;
        end
        if (last !== e.last) begin
            $display("%0t: m_last expected %0d actual %0d", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module testbench;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_command;
    logic [7:0] s_data_in;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [7:0] m_data_out;
    logic       m_last;

    line_echo_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    terminal_line_assembler DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_data_in  (s_data_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_data_out (m_data_out),
        .m_last     (m_last)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20000000;
        $display("testbench failed");
        $finish;
    end

    // receiver: random back-pressure, plus a long counted hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_output(m_kind, m_data_out, m_last);
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_data_in <= b;
        do @(posedge aclk); while (!s_ready);
        sb.accept_keystroke(cmd, b);
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(tla_pkg::CMD_BYTE, b);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == tla_pkg::CH_CR) ? 8'h20 : b;
    endfunction

    task automatic send_line(input int len);
        for (int i = 0; i < len; i++)
            send_byte(text_byte());
        if ($urandom_range(9) == 0)
            send_item(tla_pkg::CMD_TIMEOUT, 8'($urandom_range(255)));
        else
            send_byte(tla_pkg::CH_CR);
    endtask

    task automatic send_random_sequence();
        int         sel;
        int         len;
        logic [7:0] arrows [4];
        arrows = '{tla_pkg::CH_UP, tla_pkg::CH_DOWN, tla_pkg::CH_LEFT, tla_pkg::CH_RIGHT};
        sel = $urandom_range(99);
        if (sel < 45) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
            send_line(len);
        end else if (sel < 65) begin
            send_byte(tla_pkg::CH_ESC);
            send_byte(tla_pkg::CH_BRACKET);
            if ($urandom_range(99) < 85) begin
                send_byte(arrows[2'($urandom_range(3))]);
            end else begin
                send_byte(text_byte());
                send_line($urandom_range(0, 3));
            end
        end else if (sel < 75) begin
            send_byte(tla_pkg::CH_ESC);
            send_line($urandom_range(0, 6));
        end else if (sel < 85) begin
            send_item(tla_pkg::CMD_TIMEOUT, 8'($urandom_range(255)));
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = tla_pkg::CMD_BYTE;
        s_data_in     = 8'h00;
        m_ready       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty CR, extreme bytes, all arrows, escape line, timeouts
        send_byte(tla_pkg::CH_CR);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h7f);
        send_byte(tla_pkg::CH_CR);
        send_byte(tla_pkg::CH_ESC); send_byte(tla_pkg::CH_BRACKET); send_byte(tla_pkg::CH_UP);
        send_byte(tla_pkg::CH_ESC); send_byte(tla_pkg::CH_BRACKET); send_byte(tla_pkg::CH_DOWN);
        send_byte(tla_pkg::CH_ESC); send_byte(tla_pkg::CH_BRACKET); send_byte(tla_pkg::CH_LEFT);
        send_byte(tla_pkg::CH_ESC); send_byte(tla_pkg::CH_BRACKET); send_byte(tla_pkg::CH_RIGHT);
        send_byte(tla_pkg::CH_ESC); send_byte(tla_pkg::CH_BRACKET); send_byte(8'h5a);
        send_byte(tla_pkg::CH_CR);
        send_item(tla_pkg::CMD_TIMEOUT, 8'hff);
        send_byte(8'h78);
        send_item(tla_pkg::CMD_TIMEOUT, 8'h00);
        send_byte(tla_pkg::CH_CR);

        send_idle_pct = 34;
        recv_idle_pct = 81;
        while (sb.items < 110)
            send_random_sequence();

        send_idle_pct = 81;
        recv_idle_pct = 34;
        while (sb.items < 200)
            send_random_sequence();

        // long receiver stall with the sender pushing back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 300;
        while (sb.items < 250)
            send_random_sequence();

        s_valid <= 1'b0;
        while (sb.expected_out.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Covered %0d inputs (%0d timeouts, %0d dropped on full line), %0d results",
                 sb.items, sb.timeouts, sb.dropped, sb.results);
        $display("Completed lines %0d, empty lines %0d, arrow keys %0d",
                 sb.lines_done, sb.empty_lines, sb.keys);
        if (sb.errors == 0 && sb.expected_out.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
design/tla_pkg.sv
design/tla_front.sv
design/tla_queue.sv
design/tla_back.sv
design/terminal_line_assembler.sv
design/tla_checker.sv
verif/testbench.sv
